### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

### rtl/kmpsm_pkg.sv
`default_nettype none

package kmpsm_pkg;

    localparam int TDATA_IN_W  = 8;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 40;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_TEXT   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_TEXT,
        OP_NONE
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] symbol;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] start;
        logic        match;
    } result_t;

endpackage

`default_nettype wire

### rtl/kmpsm_front.sv
`default_nettype none

module kmpsm_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [kmpsm_pkg::TDATA_IN_W-1:0]   s_tdata,
    input  wire logic [kmpsm_pkg::TUSER_IN_W-1:0]   s_tuser,
    output logic                                    q_valid,
    output kmpsm_pkg::item_t                        q_item,
    input  wire logic                               q_pop
);
    import kmpsm_pkg::*;

    localparam int QDEPTH = 2;

    item_t      entry_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      in_item;
    logic       push;
    logic       pop;

    always_comb begin
        in_item.symbol = s_tdata;
        unique case (s_tuser)
            FUNC_CLEAR:  in_item.kind = OP_CLEAR;
            FUNC_APPEND: in_item.kind = OP_APPEND;
            FUNC_TEXT:   in_item.kind = OP_TEXT;
            default:     in_item.kind = OP_NONE;
        endcase
    end

    assign s_tready = count_reg != 2'(QDEPTH);
    assign q_valid  = count_reg != 2'd0;
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/kmpsm_back.sv
`default_nettype none

module kmpsm_back #(
    parameter int PATTERN_MAX = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire kmpsm_pkg::item_t    q_item,
    output logic                     q_pop,
    output logic                     res_valid,
    output kmpsm_pkg::result_t       res,
    input  wire logic                res_ready
);
    import kmpsm_pkg::*;

    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LW = $clog2(PATTERN_MAX + 1);

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } state_t;

    state_t          state_reg;
    op_kind_t        kind_reg;
    logic [7:0]      sym_reg;
    logic [AW-1:0]   k_reg;
    logic [LW-1:0]   len_reg;
    logic [AW-1:0]   bp_reg;
    logic [AW-1:0]   matched_reg;
    logic [31:0]     idx_reg;
    logic            res_valid_reg;
    result_t         res_reg;

    logic [7:0]      pat_mem  [PATTERN_MAX];
    logic [AW-1:0]   fail_mem [PATTERN_MAX];
    logic [7:0]      pat_q;
    logic [AW-1:0]   fail_q;

    logic            slot_free;
    logic            take;
    logic            pat_full;
    logic            pat_empty;
    logic            hit;
    logic            fall;
    logic [LW-1:0]   k_ext;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [7:0]      wr_sym;
    logic [AW-1:0]   wr_fail;
    logic [31:0]     idx_next;
    logic [31:0]     start_next;

    assign slot_free = !res_valid_reg || res_ready;
    assign take      = (state_reg == ST_IDLE) && q_valid && slot_free;
    assign q_pop     = take;
    assign pat_full  = len_reg == LW'(PATTERN_MAX);
    assign pat_empty = len_reg == '0;
    assign hit       = pat_q == sym_reg;
    assign fall      = (k_reg != '0) && !hit;
    assign k_ext     = LW'(k_reg) + LW'(hit);
    assign idx_next  = (idx_reg == '1) ? idx_reg : idx_reg + 32'd1;
    assign start_next = idx_reg - 32'(len_reg) + 32'd1;

    always_comb begin
        if (state_reg == ST_CHECK) begin
            rd_addr = fail_q;
            wr_en   = !fall && (kind_reg == OP_APPEND);
            wr_sym  = sym_reg;
            wr_fail = k_ext[AW-1:0];
        end else begin
            rd_addr = (q_item.kind == OP_APPEND) ? bp_reg : matched_reg;
            wr_en   = take && (q_item.kind == OP_APPEND) && !pat_full && pat_empty;
            wr_sym  = q_item.symbol;
            wr_fail = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pat_mem[len_reg[AW-1:0]]  <= wr_sym;
            fail_mem[len_reg[AW-1:0]] <= wr_fail;
        end
        pat_q  <= pat_mem[rd_addr];
        fail_q <= fail_mem[rd_addr - AW'(1)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            bp_reg        <= '0;
            matched_reg   <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        kind_reg <= q_item.kind;
                        sym_reg  <= q_item.symbol;
                        res_reg  <= '{status: STATUS_OK, start: 32'd0, match: 1'b0};
                        unique case (q_item.kind)
                            OP_CLEAR: begin
                                len_reg       <= '0;
                                bp_reg        <= '0;
                                matched_reg   <= '0;
                                idx_reg       <= '0;
                                res_valid_reg <= 1'b1;
                            end
                            OP_APPEND: begin
                                if (pat_full) begin
                                    res_reg.status <= STATUS_FULL;
                                    res_valid_reg  <= 1'b1;
                                end else if (pat_empty) begin
                                    bp_reg        <= '0;
                                    len_reg       <= LW'(1);
                                    res_valid_reg <= 1'b1;
                                end else begin
                                    k_reg     <= bp_reg;
                                    state_reg <= ST_CHECK;
                                end
                            end
                            OP_TEXT: begin
                                if (pat_empty) begin
                                    idx_reg        <= idx_next;
                                    res_reg.status <= STATUS_EMPTY;
                                    res_valid_reg  <= 1'b1;
                                end else begin
                                    k_reg     <= matched_reg;
                                    state_reg <= ST_CHECK;
                                end
                            end
                            default: begin
                                res_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_CHECK: begin
                    if (fall) begin
                        k_reg <= fail_q;
                    end else begin
                        state_reg     <= ST_IDLE;
                        res_valid_reg <= 1'b1;
                        if (kind_reg == OP_APPEND) begin
                            bp_reg  <= k_ext[AW-1:0];
                            len_reg <= len_reg + LW'(1);
                        end else begin
                            idx_reg <= idx_next;
                            if (k_ext == len_reg) begin
                                matched_reg   <= bp_reg;
                                res_reg.match <= 1'b1;
                                res_reg.start <= start_next;
                            end else begin
                                matched_reg <= k_ext[AW-1:0];
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### rtl/kmp_stream_matcher_top.sv
// Channel   Direction  tdata (low bit up)                          tuser
// s_        in         symbol[7:0]                                 func[1:0]
// m_        out        match, match_start[31:0], status[1:0], pad  none
//
// A clear, an ignored append, an append of the first byte, an unknown func and
// a text byte with an empty pattern are done in the back end's idle state; other
// appends and text bytes go through the check state, one failure-table step at
// a time, a loop bound by the registered read of the pattern and failure
// memories. Reset is synchronous and clears control state only. A two-entry
// queue keeps taking transfers while a result waits, until both entries fill.
`default_nettype none

module kmp_stream_matcher_top #(
    parameter int PATTERN_MAX = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [kmpsm_pkg::TDATA_IN_W-1:0]    s_tdata,  // symbol
    input  wire logic [kmpsm_pkg::TUSER_IN_W-1:0]    s_tuser,  // func
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [kmpsm_pkg::TDATA_OUT_W-1:0]        m_tdata   // match, match_start, status
);
    import kmpsm_pkg::*;

    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t res;

    kmpsm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    kmpsm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {{(TDATA_OUT_W - $bits(result_t)){1'b0}}, res};

endmodule

`default_nettype wire

### rtl/kmpsm_checker.sv
`default_nettype none
`include "assert_macros.svh"

module kmpsm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    `ASSERT_NEXT_ALWAYS(a_idle_after_reset, aclk, !aresetn, !m_tvalid)
    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_SAME(a_start_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0)
    `ASSERT_SAME(a_match_ok, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[34:33] == 2'd0)
    `ASSERT_SAME(a_status_code, aclk, aresetn, m_tvalid, m_tdata[34:33] != 2'd3 && m_tdata[39:35] == 5'd0)

endmodule

bind kmp_stream_matcher_top kmpsm_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/sv/kmp_stream_matcher_top_tb.sv
`timescale 1ns / 1ps

module kmp_stream_matcher_top_tb;

    import kmpsm_pkg::*;

    localparam int PATTERN_MAX  = 64;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_GOAL    = 1550;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic [TUSER_IN_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;

    logic [7:0]  pat_bytes [0:PATTERN_MAX-1];
    int          pat_fail  [0:PATTERN_MAX-1];
    int          pat_len;
    int          border_len;
    int          match_len;
    logic [31:0] text_pos;

    result_t     expected_results [$];
    int          failure_count;
    int          items_sent;
    bit          steady_flow;
    int          receiver_hold;

    kmp_stream_matcher_top #(
        .PATTERN_MAX(PATTERN_MAX)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic result_t predict_matcher_result(input op_kind_t op, input logic [7:0] sym);
        result_t res;
        int      k;
        res = '0;
        case (op)
            OP_CLEAR: begin
                pat_len    = 0;
                border_len = 0;
                match_len  = 0;
                text_pos   = '0;
            end
            OP_APPEND: begin
                if (pat_len >= PATTERN_MAX) begin
                    res.status = STATUS_FULL;
                end else begin
                    k = 0;
                    if (pat_len > 0) begin
                        k = border_len;
                        while (k > 0 && pat_bytes[k] != sym) k = pat_fail[k-1];
                        if (pat_bytes[k] == sym) k++;
                    end
                    pat_bytes[pat_len] = sym;
                    pat_fail[pat_len]  = k;
                    border_len         = k;
                    pat_len++;
                end
            end
            OP_TEXT: begin
                if (pat_len == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    k = match_len;
                    while (k > 0 && k < PATTERN_MAX && pat_bytes[k] != sym) k = pat_fail[k-1];
                    if (k < PATTERN_MAX && pat_bytes[k] == sym) k++;
                    if (k >= pat_len) begin
                        res.match = 1'b1;
                        res.start = text_pos - 32'(pat_len - 1);
                        k = pat_fail[pat_len-1];
                    end
                    match_len = k;
                end
                if (text_pos != 32'hFFFF_FFFF) text_pos++;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic send_item(input op_kind_t op, input logic [7:0] sym);
        int      gap;
        result_t want;
        gap = steady_flow ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = predict_matcher_result(op, sym);
        expected_results = {expected_results, want};
        if (op != OP_NONE) items_sent++;
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: tdata %h", m_tdata);
                failure_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.match) begin
                    $error("match: expected %0d, actual %0d", want.match, m_tdata[0]);
                    failure_count++;
                end
                if (m_tdata[32:1] !== want.start) begin
                    $error("match_start: expected %0d, actual %0d", want.start, m_tdata[32:1]);
                    failure_count++;
                end
                if (m_tdata[34:33] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[34:33]);
                    failure_count++;
                end
                if (m_tdata[39:35] !== 5'd0) begin
                    $error("pad: expected %0d, actual %0d", 0, m_tdata[39:35]);
                    failure_count++;
                end
            end
        end
    end

    initial begin : result_sink
        int wait_cycles;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            wait_cycles = steady_flow ? 0 : $urandom_range(0, 9);
            if (receiver_hold > 0) begin
                wait_cycles += receiver_hold;
                receiver_hold = 0;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic test_directed_cases();
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_NONE, 8'h5A);
        send_item(OP_CLEAR, 8'hFF);
        send_item(OP_APPEND, 8'h00);
        send_item(OP_TEXT, 8'h00);
        send_item(OP_TEXT, 8'h00);
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_APPEND, 8'hAB);
        send_item(OP_APPEND, 8'hCD);
        send_item(OP_APPEND, 8'hAB);
        send_item(OP_TEXT, 8'hAB);
        send_item(OP_TEXT, 8'hCD);
        send_item(OP_TEXT, 8'hAB);
        send_item(OP_TEXT, 8'hCD);
        send_item(OP_TEXT, 8'hAB);
        send_item(OP_APPEND, 8'hCD);
        send_item(OP_TEXT, 8'hCD);
        send_item(OP_TEXT, 8'hAB);
        send_item(OP_TEXT, 8'hCD);
        send_item(OP_TEXT, 8'h00);
        send_item(OP_NONE, 8'hFF);
        send_item(OP_CLEAR, 8'h00);
    endtask

    task automatic test_full_pattern();
        logic [7:0] full_pat [0:PATTERN_MAX-1];
        int         i;
        send_item(OP_CLEAR, 8'h00);
        for (i = 0; i < PATTERN_MAX; i++) begin
            full_pat[i] = (i % 5 == 4) ? 8'h80 : 8'h7F;
            send_item(OP_APPEND, full_pat[i]);
        end
        send_item(OP_APPEND, 8'hFF);
        send_item(OP_APPEND, 8'h00);
        for (i = 0; i < PATTERN_MAX; i++) send_item(OP_TEXT, full_pat[i]);
        for (i = PATTERN_MAX - 10; i < PATTERN_MAX; i++) send_item(OP_TEXT, full_pat[i]);
        send_item(OP_TEXT, 8'h01);
        send_item(OP_CLEAR, 8'h00);
    endtask

    task automatic test_output_backpressure();
        int i;
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_APPEND, 8'h3C);
        send_item(OP_APPEND, 8'hC3);
        steady_flow   = 1'b1;
        receiver_hold = HOLD_CYCLES;
        for (i = 0; i < 40; i++) send_item(OP_TEXT, (i % 3 == 2) ? 8'h00 : ((i % 2) ? 8'hC3 : 8'h3C));
        steady_flow = 1'b0;
    endtask

    task automatic test_random_sequences();
        logic [7:0] alphabet [0:3];
        logic [7:0] pat_copy [0:PATTERN_MAX-1];
        logic [7:0] sym;
        int         alpha_size;
        int         pat_target;
        int         pat_held;
        int         text_len;
        int         pick;
        int         i;
        int         j;
        while (items_sent < ITEM_GOAL) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            alpha_size  = $urandom_range(1, 4);
            for (i = 0; i < alpha_size; i++) alphabet[i] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) != 0) send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            pick = $urandom_range(0, 19);
            if (pick == 0) pat_target = 0;
            else if (pick == 1) pat_target = PATTERN_MAX + $urandom_range(1, 2);
            else if (pick < 4) pat_target = $urandom_range(20, PATTERN_MAX - 1);
            else pat_target = $urandom_range(1, 6);
            pat_held = 0;
            for (i = 0; i < pat_target; i++) begin
                sym = alphabet[$urandom_range(0, alpha_size - 1)];
                send_item(OP_APPEND, sym);
                if (pat_held < PATTERN_MAX) begin
                    pat_copy[pat_held] = sym;
                    pat_held++;
                end
            end
            text_len = $urandom_range(8, 40);
            i = 0;
            while (i < text_len) begin
                pick = $urandom_range(0, 39);
                if (pick == 0) begin
                    send_item(OP_APPEND, alphabet[$urandom_range(0, alpha_size - 1)]);
                end else if (pick == 1) begin
                    send_item(OP_NONE, 8'($urandom_range(0, 255)));
                end else if (pick == 2) begin
                    send_item(OP_TEXT, 8'($urandom_range(0, 255)));
                end else if (pick < 12 && pat_held > 0) begin
                    for (j = 0; j < pat_held; j++) send_item(OP_TEXT, pat_copy[j]);
                    i += pat_held;
                end else begin
                    send_item(OP_TEXT, alphabet[$urandom_range(0, alpha_size - 1)]);
                end
                i++;
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= OP_CLEAR;
        failure_count = 0;
        items_sent    = 0;
        steady_flow   = 1'b0;
        receiver_hold = 0;
        pat_len       = 0;
        border_len    = 0;
        match_len     = 0;
        text_pos      = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_full_pattern();
        test_output_backpressure();
        test_random_sequences();

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failure_count == 0) begin
            $display("kmp_stream_matcher_top_tb: clean");
        end else begin
            $display("kmp_stream_matcher_top_tb: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("kmp_stream_matcher_top_tb: errors");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/kmpsm_pkg.sv
rtl/kmpsm_front.sv
rtl/kmpsm_back.sv
rtl/kmp_stream_matcher_top.sv
rtl/kmpsm_checker.sv
tb/sv/kmp_stream_matcher_top_tb.sv
